### hdl/lsu_pkg.sv
// Package with the types and constants shared by the literal string unescaper.
`timescale 1ns / 1ps

package lsu_pkg;

    localparam int DEPTH_BITS = 8;

    typedef logic [DEPTH_BITS-1:0] depth_t;

    localparam depth_t DEPTH_ONE = depth_t'(1);
    localparam depth_t DEPTH_MAX = {DEPTH_BITS{1'b1}};

    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Pending line-break pair byte to drop.
    typedef enum logic [1:0] {
        SKIP_NONE = 2'd0,
        SKIP_CR   = 2'd1,
        SKIP_LF   = 2'd2
    } skip_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    // Up to three results caused by one input item.
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } bundle_t;

endpackage

### hdl/lsu_if.sv
// Valid/ready stream interfaces for the input bytes and the decoded results.
`timescale 1ns / 1ps

interface lsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       begin_req;
    logic       buffer_end;

    modport source (output valid, output in_byte, output begin_req, output buffer_end,
                    input ready);
    modport sink (input valid, input in_byte, input begin_req, input buffer_end,
                  output ready);
endinterface

interface lsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output kind, output out_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input kind, input out_byte, input last_of_run,
                  output ready);
endinterface

### hdl/lsu_decoder.sv
// Input register, decoder state and the single-pass decode of one byte.
`timescale 1ns / 1ps

module lsu_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              begin_req,
    input  logic              buffer_end,
    input  logic              load_ok,
    output logic              bundle_valid,
    output lsu_pkg::bundle_t  bundle
);
    import lsu_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       begin_reg;
    logic       end_reg;

    depth_t     depth_reg,  depth_next;
    logic       esc_reg,    esc_next;
    logic [7:0] acc_reg,    acc_next;
    logic [1:0] dig_reg,    dig_next;
    skip_t      skip_reg,   skip_next;
    logic       open_reg,   open_next;

    logic       advance;

    // Decode of the registered byte against the current state.
    always_comb
    begin
        logic       was_esc;
        logic       done;
        logic [1:0] n;
        logic [7:0] c;

        depth_next = depth_reg;
        esc_next   = esc_reg;
        acc_next   = acc_reg;
        dig_next   = dig_reg;
        skip_next  = skip_reg;
        open_next  = open_reg;
        bundle     = '0;
        n          = 2'd0;
        c          = byte_reg;
        was_esc    = 1'b0;
        done       = 1'b0;

        if (begin_reg)
        begin
            depth_next = DEPTH_ONE;
            esc_next   = 1'b0;
            acc_next   = 8'd0;
            dig_next   = 2'd0;
            skip_next  = SKIP_NONE;
            open_next  = 1'b1;
        end

        if (open_next)
        begin
            was_esc = esc_next;

            case (skip_next)
                SKIP_CR: done = (c == CH_CR);
                SKIP_LF: done = (c == CH_LF);
                default: done = 1'b0;
            endcase
            skip_next = SKIP_NONE;

            if (!done && dig_next != 2'd0)
            begin
                if (c inside {[CH_ZERO:CH_SEVEN]})
                begin
                    acc_next = {acc_next[4:0], c[2:0]};
                    if (dig_next == 2'd2)
                    begin
                        bundle.res[n] = '{kind: KIND_DATA, data: acc_next};
                        n        = n + 2'd1;
                        acc_next = 8'd0;
                        dig_next = 2'd0;
                    end
                    else
                    begin
                        dig_next = dig_next + 2'd1;
                    end
                    done = 1'b1;
                end
                else
                begin
                    bundle.res[n] = '{kind: KIND_DATA, data: acc_next};
                    n        = n + 2'd1;
                    acc_next = 8'd0;
                    dig_next = 2'd0;
                end
            end

            if (!done)
            begin
                esc_next = 1'b0;
                case (c)
                    CH_BACKSLASH:
                    begin
                        if (was_esc)
                        begin
                            bundle.res[n] = '{kind: KIND_DATA, data: CH_BACKSLASH};
                            n = n + 2'd1;
                        end
                        else
                        begin
                            esc_next = 1'b1;
                        end
                    end
                    CH_N, CH_R, CH_T, CH_B, CH_F:
                    begin
                        bundle.res[n].kind = KIND_DATA;
                        if (!was_esc)
                            bundle.res[n].data = c;
                        else if (c == CH_N)
                            bundle.res[n].data = CH_LF;
                        else if (c == CH_R)
                            bundle.res[n].data = CH_CR;
                        else if (c == CH_T)
                            bundle.res[n].data = CH_TAB;
                        else if (c == CH_B)
                            bundle.res[n].data = CH_BS;
                        else
                            bundle.res[n].data = CH_FF;
                        n = n + 2'd1;
                    end
                    CH_LF, CH_CR:
                    begin
                        if (was_esc)
                        begin
                            // An escaped LF drops a following CR, and the other way round.
                            skip_next = (c == CH_LF) ? SKIP_CR : SKIP_LF;
                        end
                        else
                        begin
                            bundle.res[n] = '{kind: KIND_DATA, data: c};
                            n = n + 2'd1;
                        end
                    end
                    CH_LPAREN:
                    begin
                        if (!was_esc && depth_next != DEPTH_MAX)
                            depth_next = depth_next + DEPTH_ONE;
                        bundle.res[n] = '{kind: KIND_DATA, data: CH_LPAREN};
                        n = n + 2'd1;
                    end
                    CH_RPAREN:
                    begin
                        if (!was_esc && depth_next <= DEPTH_ONE)
                        begin
                            bundle.res[n] = '{kind: KIND_CLOSE, data: 8'd0};
                            n          = n + 2'd1;
                            depth_next = '0;
                            esc_next   = 1'b0;
                            acc_next   = 8'd0;
                            dig_next   = 2'd0;
                            skip_next  = SKIP_NONE;
                            open_next  = 1'b0;
                        end
                        else
                        begin
                            if (!was_esc)
                                depth_next = depth_next - DEPTH_ONE;
                            bundle.res[n] = '{kind: KIND_DATA, data: CH_RPAREN};
                            n = n + 2'd1;
                        end
                    end
                    default:
                    begin
                        if (c inside {[CH_ZERO:CH_SEVEN]} && was_esc)
                        begin
                            acc_next = {5'd0, c[2:0]};
                            dig_next = 2'd1;
                        end
                        else
                        begin
                            bundle.res[n] = '{kind: KIND_DATA, data: c};
                            n = n + 2'd1;
                        end
                    end
                endcase
            end

            if (open_next && end_reg)
            begin
                if (dig_next != 2'd0)
                begin
                    bundle.res[n] = '{kind: KIND_DATA, data: acc_next};
                    n = n + 2'd1;
                end
                bundle.res[n] = '{kind: KIND_ERROR, data: 8'd0};
                n          = n + 2'd1;
                depth_next = '0;
                esc_next   = 1'b0;
                acc_next   = 8'd0;
                dig_next   = 2'd0;
                skip_next  = SKIP_NONE;
                open_next  = 1'b0;
            end
        end

        bundle.count = n;
    end

    assign bundle_valid = in_valid_reg && (bundle.count != 2'd0);
    assign advance      = in_valid_reg && ((bundle.count == 2'd0) || load_ok);
    assign in_ready     = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            depth_reg    <= '0;
            esc_reg      <= 1'b0;
            acc_reg      <= 8'd0;
            dig_reg      <= 2'd0;
            skip_reg     <= SKIP_NONE;
            open_reg     <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                depth_reg <= depth_next;
                esc_reg   <= esc_next;
                acc_reg   <= acc_next;
                dig_reg   <= dig_next;
                skip_reg  <= skip_next;
                open_reg  <= open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg  <= in_byte;
            begin_reg <= begin_req;
            end_reg   <= buffer_end;
        end
    end

    a_closed_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (depth_reg == '0 && !esc_reg && dig_reg == 2'd0 && skip_reg == SKIP_NONE))
        else $error("closed string left decoder state behind");

    a_octal_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        dig_reg != 2'd0 |-> (!esc_reg && skip_reg == SKIP_NONE))
        else $error("octal collection overlaps another escape state");

    a_open_has_depth: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> depth_reg != '0)
        else $error("open string with zero nesting depth");

endmodule

### hdl/lsu_emitter.sv
// Result register that hands out the results of one item, one per cycle while out_ready is high.
`timescale 1ns / 1ps

module lsu_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              bundle_valid,
    input  lsu_pkg::bundle_t  bundle,
    output logic              load_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        kind,
    output logic [7:0]        out_byte,
    output logic              last_of_run
);
    import lsu_pkg::*;

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [1:0] count_reg;
    result_t    res_reg [3];
    logic       fire;
    logic       is_last;

    assign is_last     = (idx_reg == count_reg - 2'd1);
    assign fire        = valid_reg && out_ready;
    assign load_ok     = !valid_reg || (fire && is_last);
    assign out_valid   = valid_reg;
    assign kind        = res_reg[idx_reg].kind;
    assign out_byte    = res_reg[idx_reg].data;
    assign last_of_run = is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (load_ok)
            begin
                valid_reg <= bundle_valid;
                idx_reg   <= 2'd0;
                if (bundle_valid)
                    count_reg <= bundle.count;
            end
            else if (fire)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && bundle_valid)
        begin
            res_reg[0] <= bundle.res[0];
            res_reg[1] <= bundle.res[1];
            res_reg[2] <= bundle.res[2];
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (count_reg != 2'd0 && idx_reg < count_reg))
        else $error("result index outside the loaded bundle");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_last) |=> (valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("run of results broken before its last item");

    a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> idx_reg == 2'd0)
        else $error("index not rewound while empty");

endmodule

### hdl/literal_string_unescaper.sv
// Top level of the literal string unescaper.
`timescale 1ns / 1ps

// The block decodes the body of a parenthesized literal string, one raw byte per input
// item, starting with the byte after the opening parenthesis (flagged by begin_req).
// Each item gives zero to three results: decoded data bytes (kind 0), a close marker
// (kind 1) at the matching close parenthesis, or an error marker (kind 2) when the item
// flagged buffer_end arrives while the string is still open; last_of_run marks the final
// result of an item. Escapes n r t b f, parentheses, backslash, octal escapes of one to
// three digits (low 8 bits kept) and escaped line breaks are handled; bytes outside a
// string are consumed silently. An item passes an input register, then the combinational
// decode logic that updates the state and loads the result register. The block takes one
// item per cycle as long as each item gives at most one result and the output is ready;
// the result register drains one result per cycle while the output is ready, holding the
// next item back until an item's last result is taken; items with no result never stall.
module literal_string_unescaper (
    input  logic       clk,
    input  logic       rst_n,
    lsu_in_if.sink     in_stream,
    lsu_out_if.source  out_stream
);
    import lsu_pkg::*;

    bundle_t bundle;
    logic    bundle_valid;
    logic    load_ok;

    lsu_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_stream.valid),
        .in_ready     (in_stream.ready),
        .in_byte      (in_stream.in_byte),
        .begin_req    (in_stream.begin_req),
        .buffer_end   (in_stream.buffer_end),
        .load_ok      (load_ok),
        .bundle_valid (bundle_valid),
        .bundle       (bundle)
    );

    lsu_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle_valid (bundle_valid),
        .bundle       (bundle),
        .load_ok      (load_ok),
        .out_valid    (out_stream.valid),
        .out_ready    (out_stream.ready),
        .kind         (out_stream.kind),
        .out_byte     (out_stream.out_byte),
        .last_of_run  (out_stream.last_of_run)
    );

endmodule

### sim/lsu_decode_checker.sv
// Checker that predicts the decoded results of the literal string unescaper and compares them.
`timescale 1ns / 1ps

module lsu_decode_checker (
    input  logic clk,
    input  logic rst_n,
    lsu_in_if    in_ch,
    lsu_out_if   out_ch,
    output int   fail_count,
    output int   outstanding
);
    import lsu_pkg::*;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } decoded_t;

    decoded_t expected_results[$];
    decoded_t got;
    decoded_t want;

    // Decoder state, kept in step with the accepted input items.
    depth_t     depth;
    logic       esc_pend;
    logic [7:0] oct_val;
    logic [1:0] oct_cnt;
    skip_t      skip_next;
    logic       in_string;

    function automatic void emit(kind_t k, logic [7:0] d);
        decoded_t r;
        r.kind = k;
        r.data = d;
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void flush_octal_byte();
        if (oct_cnt != 2'd0)
        begin
            emit(KIND_DATA, oct_val);
            oct_cnt = 2'd0;
            oct_val = 8'd0;
        end
    endfunction

    function automatic void end_string();
        depth     = '0;
        esc_pend  = 1'b0;
        oct_val   = 8'd0;
        oct_cnt   = 2'd0;
        skip_next = SKIP_NONE;
        in_string = 1'b0;
    endfunction

    function automatic void decode_byte(logic [7:0] c);
        logic       was_esc;
        logic [7:0] pair;
        was_esc = esc_pend;
        if (skip_next != SKIP_NONE)
        begin
            pair = (skip_next == SKIP_CR) ? CH_CR : CH_LF;
            skip_next = SKIP_NONE;
            if (c == pair)
                return;
        end
        if (oct_cnt != 2'd0)
        begin
            if (c >= CH_ZERO && c <= CH_SEVEN)
            begin
                oct_val = {oct_val[4:0], c[2:0]};
                oct_cnt = oct_cnt + 2'd1;
                if (oct_cnt == 2'd3)
                    flush_octal_byte();
                return;
            end
            flush_octal_byte();
        end
        esc_pend = 1'b0;
        if (c >= CH_ZERO && c <= CH_SEVEN)
        begin
            if (was_esc)
            begin
                oct_val = {5'd0, c[2:0]};
                oct_cnt = 2'd1;
            end
            else
                emit(KIND_DATA, c);
            return;
        end
        case (c)
            CH_BACKSLASH:
                if (was_esc)
                    emit(KIND_DATA, CH_BACKSLASH);
                else
                    esc_pend = 1'b1;
            CH_N: emit(KIND_DATA, was_esc ? CH_LF : CH_N);
            CH_R: emit(KIND_DATA, was_esc ? CH_CR : CH_R);
            CH_T: emit(KIND_DATA, was_esc ? CH_TAB : CH_T);
            CH_B: emit(KIND_DATA, was_esc ? CH_BS : CH_B);
            CH_F: emit(KIND_DATA, was_esc ? CH_FF : CH_F);
            CH_LF:
                if (was_esc)
                    skip_next = SKIP_CR;
                else
                    emit(KIND_DATA, CH_LF);
            CH_CR:
                if (was_esc)
                    skip_next = SKIP_LF;
                else
                    emit(KIND_DATA, CH_CR);
            CH_LPAREN:
            begin
                if (!was_esc && depth != DEPTH_MAX)
                    depth = depth + DEPTH_ONE;
                emit(KIND_DATA, CH_LPAREN);
            end
            CH_RPAREN:
            begin
                if (!was_esc)
                begin
                    if (depth <= DEPTH_ONE)
                    begin
                        emit(KIND_CLOSE, 8'd0);
                        end_string();
                        return;
                    end
                    depth = depth - DEPTH_ONE;
                end
                emit(KIND_DATA, CH_RPAREN);
            end
            default: emit(KIND_DATA, c);
        endcase
    endfunction

    function automatic void predict_item(logic [7:0] c, logic opens, logic ends);
        int       before_n;
        decoded_t tail;
        before_n = expected_results.size();
        if (opens)
        begin
            end_string();
            depth = DEPTH_ONE;
            in_string = 1'b1;
        end
        if (!in_string)
            return;
        decode_byte(c);
        if (in_string && ends)
        begin
            flush_octal_byte();
            emit(KIND_ERROR, 8'd0);
            end_string();
        end
        if (expected_results.size() > before_n)
        begin
            tail = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_string();
            expected_results.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.in_byte, in_ch.begin_req, in_ch.buffer_end);
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind = kind_t'(out_ch.kind);
                got.data = out_ch.out_byte;
                got.last = out_ch.last_of_run;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: kind %0d byte %02h last %0b",
                                 got.kind, got.data, got.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data
                        || got.last !== want.last)
                    begin
                        fail_count++;
                        // Both sides are printed as kind, byte and last flag.
                        if (fail_count <= 10)
                            $display("result mismatch: expected %0d %02h %0b, got %0d %02h %0b",
                                     want.kind, want.data, want.last,
                                     got.kind, got.data, got.last);
                    end
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

### sim/literal_string_unescaper_tb.sv
// Testbench top for the literal string unescaper: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module literal_string_unescaper_tb;

    import lsu_pkg::*;

    // One raw byte on the input stream together with its two flags.
    typedef struct {
        logic [7:0] ch;
        logic       opens;
        logic       ends;
    } raw_item_t;

    // Cycles with no item accepted on either side before the run is declared hung.
    localparam int HANG_LIMIT = 1000;

    logic clk;
    logic rst_n;

    lsu_in_if  in_ch();
    lsu_out_if out_ch();

    int fail_count;
    int outstanding;

    raw_item_t stim_q[$];
    bit        opens_next;
    int        string_bytes;
    int        sent_count;
    int        hang_cycles;
    bit        steady;

    literal_string_unescaper dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch)
    );

    // The checker watches both streams, keeps its own copy of the decoder state and
    // counts every wrong, missing-expectation or extra result.
    lsu_decode_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side drops ready at random with a probability of 22 percent, except during the steady
    // stretch in the middle of the random part, where it always takes the result.
    always @(posedge clk)
    begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 22);
    end

    // Watchdog: a correct run never goes this long without moving an item on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                hang_cycles = 0;
            else
                hang_cycles++;
            if (hang_cycles >= HANG_LIMIT)
            begin
                $display("literal_string_unescaper_tb: done, errors");
                $finish;
            end
        end
    end

    function automatic void queue_item(logic [7:0] ch, logic opens, logic ends);
        raw_item_t it;
        it.ch = ch;
        it.opens = opens;
        it.ends = ends;
        stim_q.push_back(it);
    endfunction

    // Appends a byte of the string being built; the first one carries begin_req.
    function automatic void put_byte(logic [7:0] ch, logic ends);
        queue_item(ch, opens_next, ends);
        opens_next = 1'b0;
        string_bytes++;
    endfunction

    // A random byte that is neither a backslash nor a parenthesis, so that it cannot
    // disturb the nesting that the string builder keeps track of.
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_BACKSLASH || c == CH_LPAREN || c == CH_RPAREN)
            c = c ^ 8'h40;
        return c;
    endfunction

    function automatic logic [7:0] escape_target();
        case ($urandom_range(0, 8))
            0: return CH_N;
            1: return CH_R;
            2: return CH_T;
            3: return CH_B;
            4: return CH_F;
            5: return CH_LPAREN;
            6: return CH_RPAREN;
            7: return CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] octal_digit();
        return CH_ZERO + 8'($urandom_range(0, 7));
    endfunction

    // Builds one string from random tokens: plain bytes, simple escapes, octal escapes,
    // escaped line breaks and nested parentheses, with a little raw noise. Most strings
    // end at their matching close; some hit the buffer end, and some are left open so
    // that the next begin_req cuts them short.
    function automatic void add_random_string();
        int n_tok;
        int opened;
        int t;
        int n_dig;
        int e;
        opens_next = 1'b1;
        opened = 1;
        n_tok = $urandom_range(1, 12);
        for (int k = 0; k < n_tok; k++)
        begin
            t = $urandom_range(0, 99);
            if (t < 30)
                put_byte(plain_byte(), 1'b0);
            else if (t < 45)
            begin
                put_byte(CH_BACKSLASH, 1'b0);
                put_byte(escape_target(), 1'b0);
            end
            else if (t < 60)
            begin
                put_byte(CH_BACKSLASH, 1'b0);
                n_dig = $urandom_range(1, 3);
                repeat (n_dig) put_byte(octal_digit(), 1'b0);
                if ($urandom_range(0, 3) == 0)
                    put_byte(octal_digit(), 1'b0);
            end
            else if (t < 70)
            begin
                put_byte(CH_BACKSLASH, 1'b0);
                case ($urandom_range(0, 5))
                    0: put_byte(CH_CR, 1'b0);
                    1: put_byte(CH_LF, 1'b0);
                    2: begin put_byte(CH_CR, 1'b0); put_byte(CH_LF, 1'b0); end
                    3: begin put_byte(CH_LF, 1'b0); put_byte(CH_CR, 1'b0); end
                    4: begin put_byte(CH_CR, 1'b0); put_byte(CH_CR, 1'b0); end
                    default: begin put_byte(CH_LF, 1'b0); put_byte(CH_LF, 1'b0); end
                endcase
            end
            else if (t < 82)
            begin
                put_byte(CH_LPAREN, 1'b0);
                opened++;
            end
            else if (t < 92)
            begin
                if (opened > 1)
                begin
                    put_byte(CH_RPAREN, 1'b0);
                    opened--;
                end
                else
                    put_byte(plain_byte(), 1'b0);
            end
            else
                put_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        e = $urandom_range(0, 99);
        if (e < 55)
            repeat (opened) put_byte(CH_RPAREN, 1'b0);
        else if (e < 65)
        begin
            repeat (opened - 1) put_byte(CH_RPAREN, 1'b0);
            put_byte(CH_RPAREN, 1'b1);
        end
        else if (e < 85)
            put_byte(plain_byte(), 1'b1);
        // Otherwise the string stays open and the next begin_req restarts the decoder.

        // Stray bytes between strings; the block ignores them once the string is closed.
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'(($urandom_range(0, 1))));
    endfunction

    // Presents one item and holds it until the block takes it. Outside the steady stretch
    // the sender may leave valid low for a while before the item.
    task automatic send_item(raw_item_t it);
        if (!steady && $urandom_range(0, 99) < 22)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.in_byte    <= it.ch;
        in_ch.begin_req  <= it.opens;
        in_ch.buffer_end <= it.ends;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic drain_stimulus();
        raw_item_t it;
        while (stim_q.size() > 0)
        begin
            it = stim_q.pop_front();
            steady = (sent_count >= 300 && sent_count < 420);
            send_item(it);
            sent_count++;
        end
        steady = 1'b0;
    endtask

    // Drops valid and waits for the checker to have seen every predicted result.
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.in_byte    = 8'd0;
        in_ch.begin_req  = 1'b0;
        in_ch.buffer_end = 1'b0;
        out_ch.ready     = 1'b0;
        steady           = 1'b0;
        opens_next       = 1'b0;
        string_bytes     = 0;
        sent_count       = 0;
        hang_cycles      = 0;
        rst_n            = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Bytes before any string, one of them flagged as buffer end,
        // must be ignored.
        queue_item(8'h41, 1'b0, 1'b0);
        queue_item(8'h00, 1'b0, 1'b1);
        // A string opening on the lowest byte, then the highest byte and an escaped n.
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'hFF, 1'b0, 1'b0);
        queue_item(CH_BACKSLASH, 1'b0, 1'b0);
        queue_item(CH_N, 1'b0, 1'b0);
        // Three-digit octal escape whose value overflows eight bits.
        queue_item(CH_BACKSLASH, 1'b0, 1'b0);
        repeat (3) queue_item(CH_SEVEN, 1'b0, 1'b0);
        // One-digit octal escape ended by a non-digit, which is then decoded itself.
        queue_item(CH_BACKSLASH, 1'b0, 1'b0);
        queue_item(CH_ZERO + 8'd1, 1'b0, 1'b0);
        queue_item(8'h78, 1'b0, 1'b0);
        // Escaped CR LF and escaped LF CR pairs are both dropped entirely.
        queue_item(CH_BACKSLASH, 1'b0, 1'b0);
        queue_item(CH_CR, 1'b0, 1'b0);
        queue_item(CH_LF, 1'b0, 1'b0);
        queue_item(CH_BACKSLASH, 1'b0, 1'b0);
        queue_item(CH_LF, 1'b0, 1'b0);
        queue_item(CH_CR, 1'b0, 1'b0);
        // A nested pair is data; the outer close parenthesis closes the string.
        queue_item(CH_LPAREN, 1'b0, 1'b0);
        queue_item(CH_RPAREN, 1'b0, 1'b0);
        queue_item(CH_RPAREN, 1'b0, 1'b0);
        // A string that starts on a backslash and runs out of buffer inside an octal
        // escape: the collected byte comes out ahead of the error.
        queue_item(CH_BACKSLASH, 1'b1, 1'b0);
        queue_item(CH_ZERO, 1'b0, 1'b0);
        queue_item(CH_ZERO + 8'd1, 1'b0, 1'b1);
        drain_stimulus();

        // Hold off until the block has delivered everything it owes.
        wait_for_results();

        // One deep string that drives the nesting depth into saturation, then backs out
        // a little and hits the buffer end while still open.
        opens_next = 1'b1;
        put_byte(8'h53, 1'b0);
        repeat (256) put_byte(CH_LPAREN, 1'b0);
        repeat (3) put_byte(CH_RPAREN, 1'b0);
        put_byte(CH_RPAREN, 1'b1);

        // Random strings with random content, enough to bring the run to about 460 items.
        string_bytes = 0;
        while (string_bytes < 175)
            add_random_string();
        drain_stimulus();

        wait_for_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("literal_string_unescaper_tb: done, clean");
        else
            $display("literal_string_unescaper_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
hdl/lsu_pkg.sv
hdl/lsu_if.sv
hdl/lsu_decoder.sv
hdl/lsu_emitter.sv
hdl/literal_string_unescaper.sv
sim/lsu_decode_checker.sv
sim/literal_string_unescaper_tb.sv
